@@ sv/btlv_pkg.sv @@
// shared types and constants of the tag/length/value stream decoder
`default_nettype none
package btlv_pkg;

  localparam int MAX_LEN_BYTES = 4;
  localparam int LEN_CNT_W     = $clog2(MAX_LEN_BYTES + 1);

  localparam logic [7:0] HDR_BYTE0   = 8'hdf;
  localparam logic [7:0] HDR_BYTE1   = 8'h80;
  localparam logic [7:0] VERSION_OFS = 8'd5;

  typedef enum logic [3:0] {
    PH_HDR0 = 4'd0,
    PH_HDR1 = 4'd1,
    PH_HDR2 = 4'd2,
    PH_LEN1 = 4'd3,
    PH_LENX = 4'd4,
    PH_TAG  = 4'd5,
    PH_VAL  = 4'd6,
    PH_SKIP = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_COMP  = 2'd1,
    KIND_VALUE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_HEADER   = 2'd0,
    ERR_LEN_FORM = 2'd1,
    ERR_OVERRUN  = 2'd2,
    ERR_NONE     = 2'd3
  } err_t;

  typedef struct packed {
    phase_t                 phase;
    logic [31:0]            accum;
    logic [LEN_CNT_W-1:0]   len_left;
    logic                   in_hdr;
    logic [7:0]             ver;
    logic [31:0]            stream_left;
    logic [31:0]            comp_left;
    logic [7:0]             tag;
    logic [31:0]            total;
    logic [31:0]            comp_len;
    logic                   ovf;
  } state_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  version;
    logic [31:0] total_length;
    logic [7:0]  tag;
    logic [31:0] comp_length;
    logic [7:0]  data_byte;
    logic        comp_last;
    logic        stream_last;
    err_t        error_code;
  } result_t;

endpackage
`default_nettype wire

@@ sv/ber_tlv_stream_decoder_core.sv @@
// top level of the byte-serial tag/length/value stream decoder
`default_nettype none
// Decodes a framed tag/length/value stream one byte per transaction: header bytes
// 0xdf 0x80, a version byte (reported minus 5), a short- or long-form length for the
// body, then components of tag, length and value bytes. Each byte gives at most one
// result transaction: stream start, component start, value byte or error. Bytes pass
// through an input register into the decode logic and the result lands in an output
// register, so the block takes one byte every clock while the result side keeps up.
// Result valid comes from the output register, loaded when the byte held in the input
// register is decoded. A stalled result holds the output register; one more byte is
// then buffered in the input register before byte_stall rises. After an error in the
// body the rest of the body is dropped silently and the decoder looks for a new
// header.
module ber_tlv_stream_decoder_core
  import btlv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // byte channel
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  stream_byte,
  // result channel
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       kind,
  output logic [7:0]       version,
  output logic [31:0]      total_length,
  output logic [7:0]       tag,
  output logic [31:0]      comp_length,
  output logic [7:0]       data_byte,
  output logic             comp_last,
  output logic             stream_last,
  output logic [1:0]       error_code
);

  // input register
  logic       in_valid;
  logic [7:0] in_data;

  // decoder state
  state_t  st;
  state_t  st_next;
  result_t res;

  logic slot_free;   // output register can take a new result this cycle
  logic advance;     // the buffered byte is decoded this cycle
  logic accept;      // byte channel transaction

  assign slot_free  = !result_valid || !result_stall;
  assign advance    = in_valid && slot_free;
  assign byte_stall = in_valid && !slot_free;
  assign accept     = byte_valid && !byte_stall;

  btlv_step u_step (
    .st      (st),
    .in_byte (in_data),
    .st_next (st_next),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data <= stream_byte;
    end
  end

  // decoder state, stepped once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_HDR0;
      st.accum       <= 32'd0;
      st.len_left    <= '0;
      st.in_hdr      <= 1'b1;
      st.ver         <= 8'd0;
      st.stream_left <= 32'd0;
      st.comp_left   <= 32'd0;
      st.tag         <= 8'd0;
      st.total       <= 32'd0;
      st.comp_len    <= 32'd0;
      st.ovf         <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res.valid;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      kind         <= res.kind;
      version      <= res.version;
      total_length <= res.total_length;
      tag          <= res.tag;
      comp_length  <= res.comp_length;
      data_byte    <= res.data_byte;
      comp_last    <= res.comp_last;
      stream_last  <= res.stream_last;
      error_code   <= res.error_code;
    end
  end

  // an error carries nothing but its code
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_ERROR) |->
      (version == 8'd0 && total_length == 32'd0 && tag == 8'd0 &&
       comp_length == 32'd0 && data_byte == 8'd0 && !comp_last && !stream_last))
    else $error("error result with nonzero payload");

  // non-error results never carry an error code
  a_no_err_code: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind != KIND_ERROR) |-> error_code == ERR_NONE)
    else $error("error code on a non-error result");

  // the last value byte of a stream also closes its component
  a_stream_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_VALUE && stream_last) |-> comp_last)
    else $error("stream ended inside a component");

  // a stream start has no component fields
  a_start_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_START) |->
      (tag == 8'd0 && comp_length == 32'd0 && !comp_last))
    else $error("stream start with component fields");

  // stall toward the byte side only while a byte is buffered
  a_stall_buffered: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (in_valid && result_valid && result_stall))
    else $error("byte stall without a buffered byte");

endmodule
`default_nettype wire

@@ sv/btlv_step.sv @@
// next-state and result logic for one stream byte
`default_nettype none
module btlv_step
  import btlv_pkg::*;
(
  input  state_t     st,
  input  logic [7:0] in_byte,
  output state_t     st_next,
  output result_t    res
);

  // what the byte caused, consumed by the output block
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    err_t        err;
    logic        cl;
    logic        sl;
    logic [31:0] len;
  } event_t;

  event_t      ev;
  logic        do_finish;
  logic [31:0] fin_len;
  logic [6:0]  n_bytes;

  assign n_bytes = in_byte[6:0];

  // next state
  always_comb begin
    st_next   = st;
    ev        = '{valid: 1'b0, kind: KIND_ERROR, err: ERR_NONE, cl: 1'b0, sl: 1'b0,
                  len: 32'd0};
    do_finish = 1'b0;
    fin_len   = 32'd0;
    unique case (st.phase)
      PH_HDR0: begin
        if (in_byte == HDR_BYTE0) begin
          st_next.phase = PH_HDR1;
        end else begin
          st_next.phase = PH_HDR0;
          ev = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_HEADER, cl: 1'b0, sl: 1'b0,
                 len: 32'd0};
        end
      end
      PH_HDR1: begin
        if (in_byte == HDR_BYTE1) begin
          st_next.phase = PH_HDR2;
        end else begin
          st_next.phase = PH_HDR0;
          ev = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_HEADER, cl: 1'b0, sl: 1'b0,
                 len: 32'd0};
        end
      end
      PH_HDR2: begin
        st_next.ver    = in_byte - VERSION_OFS;
        st_next.in_hdr = 1'b1;
        st_next.phase  = PH_LEN1;
      end
      PH_TAG: begin
        st_next.stream_left = st.stream_left - 32'd1;
        st_next.tag         = in_byte;
        if (st_next.stream_left == 32'd0) begin
          st_next.phase = PH_HDR0;
          ev = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_OVERRUN, cl: 1'b0, sl: 1'b0,
                 len: 32'd0};
        end else begin
          st_next.phase = PH_LEN1;
        end
      end
      PH_LEN1: begin
        if (!st.in_hdr) begin
          st_next.stream_left = st.stream_left - 32'd1;
        end
        st_next.ovf = 1'b0;
        if (!in_byte[7]) begin
          st_next.accum = {24'd0, in_byte};
          do_finish     = 1'b1;
          fin_len       = {24'd0, in_byte};
        end else if (n_bytes == 7'd0 || n_bytes > 7'(MAX_LEN_BYTES)) begin
          // bad long form: skip the body only inside a component length
          st_next.phase = (!st.in_hdr && st_next.stream_left != 32'd0) ? PH_SKIP : PH_HDR0;
          ev = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_LEN_FORM, cl: 1'b0, sl: 1'b0,
                 len: 32'd0};
        end else begin
          st_next.accum    = 32'd0;
          st_next.len_left = n_bytes[LEN_CNT_W-1:0];
          if (!st.in_hdr && st_next.stream_left == 32'd0) begin
            st_next.phase = PH_HDR0;
            ev = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_OVERRUN, cl: 1'b0, sl: 1'b0,
                   len: 32'd0};
          end else begin
            st_next.phase = PH_LENX;
          end
        end
      end
      PH_LENX: begin
        if (!st.in_hdr) begin
          st_next.stream_left = st.stream_left - 32'd1;
        end
        if (st.accum[31:24] != 8'd0) begin
          st_next.ovf = 1'b1;
        end
        st_next.accum    = {st.accum[23:0], in_byte};
        st_next.len_left = st.len_left - LEN_CNT_W'(1);
        if (st_next.len_left == '0) begin
          do_finish = 1'b1;
          fin_len   = st_next.accum;
        end else if (!st.in_hdr && st_next.stream_left == 32'd0) begin
          st_next.phase = PH_HDR0;
          ev = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_OVERRUN, cl: 1'b0, sl: 1'b0,
                 len: 32'd0};
        end
      end
      PH_VAL: begin
        st_next.stream_left = st.stream_left - 32'd1;
        st_next.comp_left   = st.comp_left - 32'd1;
        ev.valid = 1'b1;
        ev.kind  = KIND_VALUE;
        ev.cl    = (st_next.comp_left == 32'd0);
        ev.sl    = (st_next.stream_left == 32'd0);
        st_next.phase = !ev.cl ? PH_VAL : (ev.sl ? PH_HDR0 : PH_TAG);
      end
      PH_SKIP: begin
        if (st.stream_left != 32'd0) begin
          st_next.stream_left = st.stream_left - 32'd1;
        end
        if (st_next.stream_left == 32'd0) begin
          st_next.phase = PH_HDR0;
        end
      end
      default: begin
        st_next.phase = PH_HDR0;
      end
    endcase

    // a complete length field: stream header or component
    if (do_finish) begin
      if (st.in_hdr) begin
        if (st_next.ovf) begin
          st_next.phase = PH_HDR0;
          ev = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_LEN_FORM, cl: 1'b0, sl: 1'b0,
                 len: 32'd0};
        end else begin
          st_next.total       = fin_len;
          st_next.stream_left = fin_len;
          ev = '{valid: 1'b1, kind: KIND_START, err: ERR_NONE, cl: 1'b0,
                 sl: (fin_len == 32'd0), len: fin_len};
          if (fin_len == 32'd0) begin
            st_next.phase = PH_HDR0;
          end else begin
            st_next.in_hdr = 1'b0;
            st_next.phase  = PH_TAG;
          end
        end
      end else if (st_next.ovf || fin_len > st_next.stream_left) begin
        st_next.phase = (st_next.stream_left != 32'd0) ? PH_SKIP : PH_HDR0;
        ev = '{valid: 1'b1, kind: KIND_ERROR, err: ERR_OVERRUN, cl: 1'b0, sl: 1'b0,
               len: 32'd0};
      end else begin
        st_next.comp_len  = fin_len;
        st_next.comp_left = fin_len;
        ev = '{valid: 1'b1, kind: KIND_COMP, err: ERR_NONE, cl: (fin_len == 32'd0),
               sl: (st_next.stream_left == 32'd0), len: fin_len};
        st_next.phase = !ev.cl ? PH_VAL : (ev.sl ? PH_HDR0 : PH_TAG);
      end
    end
  end

  // result fields
  always_comb begin
    res             = '0;
    res.valid       = ev.valid;
    res.kind        = ev.kind;
    res.error_code  = ev.err;
    res.comp_last   = ev.cl;
    res.stream_last = ev.sl;
    unique case (ev.kind)
      KIND_START: begin
        res.version      = st_next.ver;
        res.total_length = ev.len;
      end
      KIND_COMP: begin
        res.version      = st_next.ver;
        res.total_length = st_next.total;
        res.tag          = st_next.tag;
        res.comp_length  = ev.len;
      end
      KIND_VALUE: begin
        res.version      = st_next.ver;
        res.total_length = st_next.total;
        res.tag          = st_next.tag;
        res.comp_length  = st_next.comp_len;
        res.data_byte    = in_byte;
      end
      default: begin
        res.comp_last   = 1'b0;
        res.stream_last = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire
